/* design/pcss_pkg.sv */
// Package for the page carousel slide sequencer.
// Holds shared constants, codes, structs and page helper functions.
// No dependencies.
`timescale 1ns / 1ps

package pcss_pkg;

   localparam int MAX_PAGES    = 16;
   localparam int PAGE_W       = 4;
   localparam int COUNT_W      = 5;
   localparam int SLIDE_W      = 16;
   localparam int TICK_BITS    = 16;
   localparam int PANEL_WIDTH  = 32;
   localparam int PANEL_HEIGHT = 8;
   localparam int QUOT_W       = $clog2(PANEL_WIDTH);
   localparam int MAG_W        = QUOT_W + 1;
   localparam int HEIGHT_SHIFT = $clog2(PANEL_WIDTH / PANEL_HEIGHT);
   localparam int CSR_ADDR_W   = 5;
   localparam int CSR_DATA_W   = 32;

   typedef enum logic [2:0] {
      ACT_TICK     = 3'd0,
      ACT_NEXT     = 3'd1,
      ACT_PREV     = 3'd2,
      ACT_JUMP     = 3'd3,
      ACT_SLIDE_TO = 3'd4
   } action_type;

   typedef enum logic [2:0] {
      CSR_PAGE_COUNT      = 3'd0,
      CSR_TICKS_PER_PAGE  = 3'd1,
      CSR_TICKS_PER_SLIDE = 3'd2,
      CSR_AUTO_ADVANCE    = 3'd3,
      CSR_SLIDE_STYLE     = 3'd4,
      CSR_AUTO_BACKWARD   = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      STYLE_LEFT  = 2'd0,
      STYLE_RIGHT = 2'd1,
      STYLE_UP    = 2'd2,
      STYLE_DOWN  = 2'd3
   } slide_style_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_SETUP,
      SEQ_DIVIDE,
      SEQ_FINISH
   } seq_state_type;

   typedef struct packed {
      logic [COUNT_W-1:0] page_count;
      logic [SLIDE_W-1:0] ticks_per_page;
      logic [SLIDE_W-1:0] ticks_per_slide;
      logic               auto_advance;
      logic [1:0]         slide_style;
   } cfg_type;

   typedef struct packed {
      logic page_count_we;
      logic direction_we;
      logic direction;
   } cfg_write_type;

   typedef struct packed {
      logic              sliding;
      logic [PAGE_W-1:0] shown_page;
      logic              direction_back;
      logic [PAGE_W-1:0] pending_page;
      logic              pending_valid;
   } carousel_type;

   function automatic logic [COUNT_W-1:0] effective_pages(logic [COUNT_W-1:0] page_count);
      logic [COUNT_W-1:0] limit;
      limit = COUNT_W'(MAX_PAGES);
      return (page_count > limit) ? limit : page_count;
   endfunction

   function automatic logic [PAGE_W-1:0] following_page(carousel_type s,
                                                        logic [COUNT_W-1:0] n);
      logic [COUNT_W-1:0] up;
      logic [COUNT_W-1:0] last;
      logic [PAGE_W-1:0]  result;
      up   = {1'b0, s.shown_page} + COUNT_W'(1);
      last = n - COUNT_W'(1);
      if (s.pending_valid) begin
         result = s.pending_page;
      end else if (n == '0) begin
         result = s.shown_page;
      end else if (s.direction_back) begin
         result = (s.shown_page == '0) ? last[PAGE_W-1:0] : s.shown_page - PAGE_W'(1);
      end else begin
         result = (up == n) ? '0 : up[PAGE_W-1:0];
      end
      return result;
   endfunction

endpackage

/* design/page_carousel_slide_sequencer.sv */
// Page carousel slide sequencer: each accepted word passes setup, five divider
// steps, divider done and finish before its result is loaded; setup goes straight
// to finish when no divide is needed. One word at a time: the next word is accepted
// once the result is loaded. The shared one-bit-per-cycle divider sets the pace; a
// held result stalls intake. Synchronous active-high reset: showing page 0, forward,
// counters cleared, auto_advance 1, other control registers 0, result data not reset.
`timescale 1ns / 1ps

module page_carousel_slide_sequencer #(
   parameter int TICK_BITS = pcss_pkg::TICK_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [2:0]                         req_action,
   input  logic [pcss_pkg::PAGE_W-1:0]        req_target_page,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [pcss_pkg::PAGE_W-1:0]        rsp_current_page,
   output logic [pcss_pkg::PAGE_W-1:0]        rsp_incoming_page,
   output logic                               rsp_sliding,
   output logic signed [6:0]                  rsp_out_x,
   output logic signed [4:0]                  rsp_out_y,
   output logic signed [7:0]                  rsp_in_x,
   output logic signed [5:0]                  rsp_in_y,
   output logic                               rsp_early_phase,
   output logic                               rsp_late_phase,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [pcss_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [pcss_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [pcss_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);

   localparam int CMP_W   = (TICK_BITS > pcss_pkg::SLIDE_W) ? TICK_BITS : pcss_pkg::SLIDE_W;
   localparam int PHASE_W = CMP_W + 3;

   pcss_pkg::cfg_type        cfg;
   pcss_pkg::cfg_write_type  cfg_wr;
   pcss_pkg::carousel_type   status;
   pcss_pkg::seq_state_type  seq_ff, seq_in;
   logic [TICK_BITS-1:0]     tick_count;
   logic [CMP_W-1:0]         tick_w;
   logic [pcss_pkg::COUNT_W-1:0] pages;
   logic                     accept;
   logic                     active;
   logic                     saturate;
   logic                     div_start;
   logic                     div_done;
   logic [pcss_pkg::QUOT_W-1:0] div_quotient;
   logic [pcss_pkg::MAG_W-1:0]  mag_ff, mag_in;
   logic [pcss_pkg::MAG_W-1:0]  mag_h;
   logic signed [7:0]        mw, mh, ox, oy, ix, iy;
   logic [PHASE_W-1:0]       five_t, tps_x, four_tps;
   logic                     load;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [pcss_pkg::PAGE_W-1:0] current_ff, incoming_ff;
   logic                     sliding_ff, early_ff, late_ff;
   logic signed [6:0]        out_x_ff;
   logic signed [4:0]        out_y_ff;
   logic signed [7:0]        in_x_ff;
   logic signed [5:0]        in_y_ff;

   pcss_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg),
      .cfg_wr      (cfg_wr)
   );

   pcss_state #(
      .TICK_BITS (TICK_BITS)
   ) u_state (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .cfg_wr      (cfg_wr),
      .accept      (accept),
      .action      (req_action),
      .target_page (req_target_page),
      .status      (status),
      .tick_count  (tick_count)
   );

   pcss_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (tick_w[pcss_pkg::SLIDE_W-1:0]),
      .divisor  (cfg.ticks_per_slide),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign req_ready = (seq_ff == pcss_pkg::SEQ_IDLE);
   assign accept    = req_valid && req_ready;
   assign pages     = pcss_pkg::effective_pages(cfg.page_count);
   assign tick_w    = CMP_W'(tick_count);
   assign active    = status.sliding && (pages != '0) && (cfg.ticks_per_slide != '0);
   assign saturate  = tick_w >= CMP_W'(cfg.ticks_per_slide);

   always_comb begin
      seq_in       = seq_ff;
      mag_in       = mag_ff;
      div_start    = 1'b0;
      load         = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (seq_ff)
         pcss_pkg::SEQ_IDLE: begin
            if (accept) seq_in = pcss_pkg::SEQ_SETUP;
         end
         pcss_pkg::SEQ_SETUP: begin
            if (!active) begin
               mag_in = '0;
               seq_in = pcss_pkg::SEQ_FINISH;
            end else if (saturate) begin
               mag_in = pcss_pkg::MAG_W'(pcss_pkg::PANEL_WIDTH);
               seq_in = pcss_pkg::SEQ_FINISH;
            end else begin
               div_start = 1'b1;
               seq_in    = pcss_pkg::SEQ_DIVIDE;
            end
         end
         pcss_pkg::SEQ_DIVIDE: begin
            if (div_done) begin
               mag_in = pcss_pkg::MAG_W'(div_quotient);
               seq_in = pcss_pkg::SEQ_FINISH;
            end
         end
         pcss_pkg::SEQ_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load         = 1'b1;
               rsp_valid_in = 1'b1;
               seq_in       = pcss_pkg::SEQ_IDLE;
            end
         end
         default: begin
            seq_in = pcss_pkg::SEQ_IDLE;
         end
      endcase
   end

   assign mag_h    = mag_ff >> pcss_pkg::HEIGHT_SHIFT;
   assign mw       = signed'(8'(mag_ff));
   assign mh       = signed'(8'(mag_h));
   assign five_t   = {PHASE_W'(tick_w) << 2} + PHASE_W'(tick_w);
   assign tps_x    = PHASE_W'(cfg.ticks_per_slide);
   assign four_tps = tps_x << 2;

   always_comb begin
      ox = '0;
      oy = '0;
      ix = '0;
      iy = '0;
      if (active) begin
         case (cfg.slide_style)
            pcss_pkg::STYLE_LEFT: begin
               ox = -mw;
               ix = 8'(pcss_pkg::PANEL_WIDTH) - mw;
            end
            pcss_pkg::STYLE_RIGHT: begin
               ox = mw;
               ix = mw - 8'(pcss_pkg::PANEL_WIDTH);
            end
            pcss_pkg::STYLE_UP: begin
               oy = -mh;
               iy = 8'(pcss_pkg::PANEL_HEIGHT) - mh;
            end
            default: begin
               oy = mh;
               iy = mh - 8'(pcss_pkg::PANEL_HEIGHT);
            end
         endcase
         if (status.direction_back) begin
            ox = -ox;
            oy = -oy;
            ix = -ix;
            iy = -iy;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= pcss_pkg::SEQ_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         seq_ff       <= seq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      if (load) begin
         current_ff  <= status.shown_page;
         incoming_ff <= pcss_pkg::following_page(status, pages);
         sliding_ff  <= status.sliding;
         out_x_ff    <= ox[6:0];
         out_y_ff    <= oy[4:0];
         in_x_ff     <= ix;
         in_y_ff     <= iy[5:0];
         early_ff    <= active && (five_t < tps_x);
         late_ff     <= active && (five_t > four_tps);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_current_page  = current_ff;
   assign rsp_incoming_page = incoming_ff;
   assign rsp_sliding       = sliding_ff;
   assign rsp_out_x         = out_x_ff;
   assign rsp_out_y         = out_y_ff;
   assign rsp_in_x          = in_x_ff;
   assign rsp_in_y          = in_y_ff;
   assign rsp_early_phase   = early_ff;
   assign rsp_late_phase    = late_ff;

endmodule

/* design/pcss_csr.sv */
// Configuration registers of the page carousel slide sequencer.
// APB-style write and read port, write strobes for state side effects.
// Depends on pcss_pkg.
`timescale 1ns / 1ps

module pcss_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [pcss_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [pcss_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [pcss_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   output pcss_pkg::cfg_type                   cfg,
   output pcss_pkg::cfg_write_type             cfg_wr
);

   logic [pcss_pkg::COUNT_W-1:0] page_count_ff, page_count_in;
   logic [pcss_pkg::SLIDE_W-1:0] ticks_per_page_ff, ticks_per_page_in;
   logic [pcss_pkg::SLIDE_W-1:0] ticks_per_slide_ff, ticks_per_slide_in;
   logic                         auto_advance_ff, auto_advance_in;
   logic [1:0]                   slide_style_ff, slide_style_in;
   logic                         auto_backward_ff, auto_backward_in;
   logic                         write_en;
   logic [2:0]                   index;

   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign index      = csr_paddr[4:2];
   assign csr_pready = 1'b1;

   always_comb begin
      page_count_in      = page_count_ff;
      ticks_per_page_in  = ticks_per_page_ff;
      ticks_per_slide_in = ticks_per_slide_ff;
      auto_advance_in    = auto_advance_ff;
      slide_style_in     = slide_style_ff;
      auto_backward_in   = auto_backward_ff;
      cfg_wr             = '0;
      csr_prdata         = '0;
      case (index)
         pcss_pkg::CSR_PAGE_COUNT: begin
            csr_prdata = pcss_pkg::CSR_DATA_W'(page_count_ff);
            if (write_en) begin
               page_count_in        = csr_pwdata[pcss_pkg::COUNT_W-1:0];
               cfg_wr.page_count_we = 1'b1;
            end
         end
         pcss_pkg::CSR_TICKS_PER_PAGE: begin
            csr_prdata = pcss_pkg::CSR_DATA_W'(ticks_per_page_ff);
            if (write_en) ticks_per_page_in = csr_pwdata[pcss_pkg::SLIDE_W-1:0];
         end
         pcss_pkg::CSR_TICKS_PER_SLIDE: begin
            csr_prdata = pcss_pkg::CSR_DATA_W'(ticks_per_slide_ff);
            if (write_en) ticks_per_slide_in = csr_pwdata[pcss_pkg::SLIDE_W-1:0];
         end
         pcss_pkg::CSR_AUTO_ADVANCE: begin
            csr_prdata = pcss_pkg::CSR_DATA_W'(auto_advance_ff);
            if (write_en) auto_advance_in = csr_pwdata[0];
         end
         pcss_pkg::CSR_SLIDE_STYLE: begin
            csr_prdata = pcss_pkg::CSR_DATA_W'(slide_style_ff);
            if (write_en) slide_style_in = csr_pwdata[1:0];
         end
         pcss_pkg::CSR_AUTO_BACKWARD: begin
            csr_prdata = pcss_pkg::CSR_DATA_W'(auto_backward_ff);
            if (write_en) begin
               auto_backward_in    = csr_pwdata[0];
               cfg_wr.direction_we = 1'b1;
               cfg_wr.direction    = csr_pwdata[0];
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_count_ff      <= '0;
         ticks_per_page_ff  <= '0;
         ticks_per_slide_ff <= '0;
         auto_advance_ff    <= 1'b1;
         slide_style_ff     <= '0;
         auto_backward_ff   <= 1'b0;
      end else begin
         page_count_ff      <= page_count_in;
         ticks_per_page_ff  <= ticks_per_page_in;
         ticks_per_slide_ff <= ticks_per_slide_in;
         auto_advance_ff    <= auto_advance_in;
         slide_style_ff     <= slide_style_in;
         auto_backward_ff   <= auto_backward_in;
      end
   end

   assign cfg.page_count      = page_count_ff;
   assign cfg.ticks_per_page  = ticks_per_page_ff;
   assign cfg.ticks_per_slide = ticks_per_slide_ff;
   assign cfg.auto_advance    = auto_advance_ff;
   assign cfg.slide_style     = slide_style_ff;

endmodule

/* design/pcss_state.sv */
// Carousel state registers and the per-word state update.
// Applies tick and manual actions and configuration side effects.
// Depends on pcss_pkg.
`timescale 1ns / 1ps

module pcss_state #(
   parameter int TICK_BITS = pcss_pkg::TICK_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pcss_pkg::cfg_type             cfg,
   input  pcss_pkg::cfg_write_type       cfg_wr,
   input  logic                          accept,
   input  logic [2:0]                    action,
   input  logic [pcss_pkg::PAGE_W-1:0]   target_page,
   output pcss_pkg::carousel_type        status,
   output logic [TICK_BITS-1:0]          tick_count
);

   localparam int CMP_W = (TICK_BITS > pcss_pkg::SLIDE_W) ? TICK_BITS : pcss_pkg::SLIDE_W;

   pcss_pkg::carousel_type state_ff, state_in;
   logic [TICK_BITS-1:0]   tick_ff, tick_in;
   logic                   saved_dir_ff, saved_dir_in;
   logic                   manual_ff, manual_in;
   logic [TICK_BITS-1:0]   tick_inc;
   logic [CMP_W-1:0]       tick_inc_w;
   logic [pcss_pkg::COUNT_W-1:0] pages;
   logic                   target_ok;

   assign pages      = pcss_pkg::effective_pages(cfg.page_count);
   assign tick_inc   = (tick_ff == {TICK_BITS{1'b1}}) ? tick_ff : tick_ff + TICK_BITS'(1);
   assign tick_inc_w = CMP_W'(tick_inc);
   assign target_ok  = {1'b0, target_page} < pages;

   always_comb begin
      state_in     = state_ff;
      tick_in      = tick_ff;
      saved_dir_in = saved_dir_ff;
      manual_in    = manual_ff;
      if (cfg_wr.page_count_we) begin
         tick_in                = '0;
         state_in.sliding       = 1'b0;
         state_in.shown_page    = '0;
         state_in.pending_valid = 1'b0;
      end else if (cfg_wr.direction_we) begin
         state_in.direction_back = cfg_wr.direction;
         saved_dir_in            = cfg_wr.direction;
      end else if (accept) begin
         case (action)
            pcss_pkg::ACT_TICK: begin
               tick_in = tick_inc;
               if (pages != '0) begin
                  if (state_ff.sliding) begin
                     if (tick_inc_w >= CMP_W'(cfg.ticks_per_slide)) begin
                        state_in.sliding       = 1'b0;
                        state_in.shown_page    = pcss_pkg::following_page(state_ff, pages);
                        tick_in                = '0;
                        state_in.pending_valid = 1'b0;
                     end
                  end else begin
                     if (manual_ff) begin
                        state_in.direction_back = saved_dir_ff;
                        manual_in               = 1'b0;
                     end
                     if (tick_inc_w >= CMP_W'(cfg.ticks_per_page)) begin
                        if (cfg.auto_advance) state_in.sliding = 1'b1;
                        tick_in = '0;
                     end
                  end
               end
            end
            pcss_pkg::ACT_NEXT, pcss_pkg::ACT_PREV: begin
               if (!state_ff.sliding) begin
                  manual_in               = 1'b1;
                  state_in.sliding        = 1'b1;
                  tick_in                 = '0;
                  saved_dir_in            = state_ff.direction_back;
                  state_in.direction_back = (action == pcss_pkg::ACT_PREV);
               end
            end
            pcss_pkg::ACT_JUMP: begin
               if (target_ok) begin
                  tick_in = '0;
                  if (target_page != state_ff.shown_page) begin
                     state_in.sliding    = 1'b0;
                     state_in.shown_page = target_page;
                  end
               end
            end
            pcss_pkg::ACT_SLIDE_TO: begin
               if (target_ok) begin
                  tick_in = '0;
                  if (target_page != state_ff.shown_page) begin
                     state_in.pending_page   = target_page;
                     state_in.pending_valid  = 1'b1;
                     saved_dir_in            = state_ff.direction_back;
                     manual_in               = 1'b1;
                     state_in.sliding        = 1'b1;
                     state_in.direction_back = target_page < state_ff.shown_page;
                  end
               end
            end
            default: begin
               tick_in = tick_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         tick_ff      <= '0;
         saved_dir_ff <= 1'b0;
         manual_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         saved_dir_ff <= saved_dir_in;
         manual_ff    <= manual_in;
      end
   end

   assign status     = state_ff;
   assign tick_count = tick_ff;

endmodule

/* design/pcss_divider.sv */
// Shared restoring divider, one quotient bit per cycle.
// Yields floor(2^QUOT_W * dividend / divisor) for dividend below divisor.
// Depends on pcss_pkg.
`timescale 1ns / 1ps

module pcss_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [pcss_pkg::SLIDE_W-1:0]      dividend,
   input  logic [pcss_pkg::SLIDE_W-1:0]      divisor,
   output logic                              done,
   output logic [pcss_pkg::QUOT_W-1:0]       quotient
);

   localparam int STEP_W = $clog2(pcss_pkg::QUOT_W + 1);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [STEP_W-1:0]               step_ff, step_in;
   logic [pcss_pkg::SLIDE_W-1:0]    rem_ff, rem_in;
   logic [pcss_pkg::QUOT_W-1:0]     quot_ff, quot_in;
   logic [pcss_pkg::SLIDE_W:0]      shifted;
   logic [pcss_pkg::SLIDE_W:0]      diff;
   logic                            fits;
   logic                            last;

   assign shifted = {rem_ff, 1'b0};
   assign diff    = shifted - {1'b0, divisor};
   assign fits    = shifted >= {1'b0, divisor};
   assign last    = step_ff == STEP_W'(pcss_pkg::QUOT_W - 1);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = dividend;
         quot_in = '0;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[pcss_pkg::SLIDE_W-1:0] : shifted[pcss_pkg::SLIDE_W-1:0];
         quot_in = {quot_ff[pcss_pkg::QUOT_W-2:0], fits};
         step_in = step_ff + STEP_W'(1);
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

/* tb/sv/page_carousel_slide_sequencer_tb.sv */
// Self-checking bench for the page carousel slide sequencer: directed and random
// action words, register writes over the APB-style port, random stalls both sides.
// Depends on pcss_pkg and page_carousel_slide_sequencer.
`timescale 1ns / 1ps

module page_carousel_slide_sequencer_tb;

   localparam int IDLE_LIMIT   = 4000;
   localparam int REPORT_LIMIT = 10;
   localparam int PHASES       = 13;
   localparam int PHASE_WORDS  = 50;
   localparam int SETTLE       = 16;
   localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
   localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;
   localparam logic [pcss_pkg::TICK_BITS-1:0] TICK_FULL = '1;

   typedef struct packed {
      logic [pcss_pkg::PAGE_W-1:0] current_page;
      logic [pcss_pkg::PAGE_W-1:0] incoming_page;
      logic              sliding;
      logic [6:0]        out_x;
      logic [4:0]        out_y;
      logic [7:0]        in_x;
      logic [5:0]        in_y;
      logic              early_phase;
      logic              late_phase;
   } carousel_view_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [2:0]            req_action = '0;
   logic [pcss_pkg::PAGE_W-1:0] req_target_page = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [pcss_pkg::PAGE_W-1:0] rsp_current_page;
   logic [pcss_pkg::PAGE_W-1:0] rsp_incoming_page;
   logic                  rsp_sliding;
   logic signed [6:0]     rsp_out_x;
   logic signed [4:0]     rsp_out_y;
   logic signed [7:0]     rsp_in_x;
   logic signed [5:0]     rsp_in_y;
   logic                  rsp_early_phase;
   logic                  rsp_late_phase;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [pcss_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [pcss_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [pcss_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // shadow registers and carousel state
   logic [pcss_pkg::COUNT_W-1:0]   cfg_page_count = '0;
   logic [pcss_pkg::SLIDE_W-1:0]   cfg_ticks_per_page = '0;
   logic [pcss_pkg::SLIDE_W-1:0]   cfg_ticks_per_slide = '0;
   logic                           cfg_auto_advance = 1'b1;
   pcss_pkg::slide_style_type      cfg_slide_style = pcss_pkg::STYLE_LEFT;
   logic                           st_sliding = 1'b0;
   logic [pcss_pkg::PAGE_W-1:0]    st_shown = '0;
   logic [pcss_pkg::TICK_BITS-1:0] st_ticks = '0;
   logic                           st_back = 1'b0;
   logic                           st_saved_back = 1'b0;
   logic                           st_manual = 1'b0;
   logic [pcss_pkg::PAGE_W-1:0]    st_pending_page = '0;
   logic                           st_pending_valid = 1'b0;

   carousel_view_type expected_views[$];
   int  failures = 0;
   int  idle_cycles = 0;
   int  rsp_stall_left = 0;
   bit  send_steady = 1'b0;
   bit  rsp_steady = 1'b0;

   page_carousel_slide_sequencer uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_target_page   (req_target_page),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_current_page  (rsp_current_page),
      .rsp_incoming_page (rsp_incoming_page),
      .rsp_sliding       (rsp_sliding),
      .rsp_out_x         (rsp_out_x),
      .rsp_out_y         (rsp_out_y),
      .rsp_in_x          (rsp_in_x),
      .rsp_in_y          (rsp_in_y),
      .rsp_early_phase   (rsp_early_phase),
      .rsp_late_phase    (rsp_late_phase),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic int pick_gap(input bit steady);
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int pages_in_use();
      return (cfg_page_count > pcss_pkg::MAX_PAGES) ? pcss_pkg::MAX_PAGES
                                                    : int'(cfg_page_count);
   endfunction

   function automatic logic [pcss_pkg::PAGE_W-1:0] neighbor_page();
      int n;
      n = pages_in_use();
      if (st_pending_valid) return st_pending_page;
      if (n == 0) return st_shown;
      if (st_back) return pcss_pkg::PAGE_W'((int'(st_shown) + n - 1) % n);
      return pcss_pkg::PAGE_W'((int'(st_shown) + 1) % n);
   endfunction

   function automatic string format_view(input carousel_view_type v);
      return $sformatf("page %0d next %0d sliding %0b out (%0d,%0d) in (%0d,%0d) early %0b late %0b",
                       v.current_page, v.incoming_page, v.sliding,
                       $signed(v.out_x), $signed(v.out_y), $signed(v.in_x), $signed(v.in_y),
                       v.early_phase, v.late_phase);
   endfunction

   task automatic begin_manual_slide(input logic back);
      if (st_sliding) return;
      st_manual     = 1'b1;
      st_sliding    = 1'b1;
      st_ticks      = '0;
      st_saved_back = st_back;
      st_back       = back;
   endtask

   task automatic advance_tick();
      if (st_ticks != TICK_FULL) st_ticks = st_ticks + 1'b1;
      if (pages_in_use() == 0) return;
      if (st_sliding) begin
         if (st_ticks >= cfg_ticks_per_slide) begin
            st_sliding       = 1'b0;
            st_shown         = neighbor_page();
            st_ticks         = '0;
            st_pending_valid = 1'b0;
         end
      end else begin
         if (st_manual) begin
            st_back   = st_saved_back;
            st_manual = 1'b0;
         end
         if (st_ticks >= cfg_ticks_per_page) begin
            if (cfg_auto_advance) st_sliding = 1'b1;
            st_ticks = '0;
         end
      end
   endtask

   task automatic apply_register(input pcss_pkg::csr_index_type idx, input logic [31:0] value);
      case (idx)
         pcss_pkg::CSR_PAGE_COUNT: begin
            cfg_page_count   = value[pcss_pkg::COUNT_W-1:0];
            st_ticks         = '0;
            st_sliding       = 1'b0;
            st_shown         = '0;
            st_pending_valid = 1'b0;
         end
         pcss_pkg::CSR_TICKS_PER_PAGE:  cfg_ticks_per_page = value[pcss_pkg::SLIDE_W-1:0];
         pcss_pkg::CSR_TICKS_PER_SLIDE: cfg_ticks_per_slide = value[pcss_pkg::SLIDE_W-1:0];
         pcss_pkg::CSR_AUTO_ADVANCE:    cfg_auto_advance = value[0];
         pcss_pkg::CSR_SLIDE_STYLE:
            cfg_slide_style = pcss_pkg::slide_style_type'(value[1:0]);
         pcss_pkg::CSR_AUTO_BACKWARD: begin
            st_back       = value[0];
            st_saved_back = value[0];
         end
         default: ;
      endcase
   endtask

   task automatic predict_view(input logic [2:0] act, input logic [pcss_pkg::PAGE_W-1:0] tgt);
      int n, mw, mh, ox, oy, ix, iy;
      logic early, late;
      carousel_view_type v;
      n = pages_in_use();
      ox = 0; oy = 0; ix = 0; iy = 0;
      early = 1'b0; late = 1'b0;
      case (act)
         pcss_pkg::ACT_TICK: advance_tick();
         pcss_pkg::ACT_NEXT: begin_manual_slide(1'b0);
         pcss_pkg::ACT_PREV: begin_manual_slide(1'b1);
         pcss_pkg::ACT_JUMP: begin
            if (int'(tgt) < n) begin
               st_ticks = '0;
               if (tgt != st_shown) begin
                  st_sliding = 1'b0;
                  st_shown   = tgt;
               end
            end
         end
         pcss_pkg::ACT_SLIDE_TO: begin
            if (int'(tgt) < n) begin
               st_ticks = '0;
               if (tgt != st_shown) begin
                  st_pending_page  = tgt;
                  st_pending_valid = 1'b1;
                  st_saved_back    = st_back;
                  st_manual        = 1'b1;
                  st_sliding       = 1'b1;
                  st_back          = (tgt < st_shown);
               end
            end
         end
         default: ;
      endcase
      if (st_sliding && n != 0 && cfg_ticks_per_slide != 0) begin
         mw = pcss_pkg::PANEL_WIDTH * int'(st_ticks) / int'(cfg_ticks_per_slide);
         mh = pcss_pkg::PANEL_HEIGHT * int'(st_ticks) / int'(cfg_ticks_per_slide);
         if (mw > pcss_pkg::PANEL_WIDTH) mw = pcss_pkg::PANEL_WIDTH;
         if (mh > pcss_pkg::PANEL_HEIGHT) mh = pcss_pkg::PANEL_HEIGHT;
         case (cfg_slide_style)
            pcss_pkg::STYLE_LEFT:  begin ox = -mw; ix = pcss_pkg::PANEL_WIDTH - mw;  end
            pcss_pkg::STYLE_RIGHT: begin ox = mw;  ix = mw - pcss_pkg::PANEL_WIDTH;  end
            pcss_pkg::STYLE_UP:    begin oy = -mh; iy = pcss_pkg::PANEL_HEIGHT - mh; end
            default:               begin oy = mh;  iy = mh - pcss_pkg::PANEL_HEIGHT; end
         endcase
         if (st_back) begin
            ox = -ox; oy = -oy; ix = -ix; iy = -iy;
         end
         early = (5 * int'(st_ticks)) < int'(cfg_ticks_per_slide);
         late  = (5 * int'(st_ticks)) > (4 * int'(cfg_ticks_per_slide));
      end
      v.current_page  = st_shown;
      v.incoming_page = neighbor_page();
      v.sliding       = st_sliding;
      v.out_x         = ox[6:0];
      v.out_y         = oy[4:0];
      v.in_x          = ix[7:0];
      v.in_y          = iy[5:0];
      v.early_phase   = early;
      v.late_phase    = late;
      expected_views.push_back(v);
   endtask

   task automatic send_word(input logic [2:0] act, input logic [pcss_pkg::PAGE_W-1:0] tgt);
      int gap;
      gap = pick_gap(send_steady);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_action      <= act;
      req_target_page <= tgt;
      do @(posedge clock); while (!req_ready);
      predict_view(act, tgt);
   endtask

   // drop valid and hold until every expected word is back
   task automatic drain_views();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_views.size() != 0);
   endtask

   task automatic write_register(input pcss_pkg::csr_index_type idx, input logic [31:0] value,
                                 input bit close_bus);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      apply_register(idx, value);
      if (close_bus) begin
         csr_psel    <= 1'b0;
         csr_penable <= 1'b0;
         csr_pwrite  <= 1'b0;
      end
   endtask

   task automatic check_frozen_carousel();
      send_word(pcss_pkg::ACT_TICK, '0);
      send_word(pcss_pkg::ACT_NEXT, '0);
      send_word(pcss_pkg::ACT_TICK, '0);
      send_word(pcss_pkg::ACT_JUMP, '0);
      send_word(pcss_pkg::ACT_SLIDE_TO, '1);
      send_word(ACT_SPARE_LAST, '1);
      drain_views();
   endtask

   task automatic check_manual_slides();
      write_register(pcss_pkg::CSR_PAGE_COUNT, pcss_pkg::MAX_PAGES, 1'b0);
      write_register(pcss_pkg::CSR_TICKS_PER_PAGE, 3, 1'b0);
      write_register(pcss_pkg::CSR_TICKS_PER_SLIDE, 6, 1'b0);
      write_register(pcss_pkg::CSR_AUTO_ADVANCE, 1, 1'b0);
      write_register(pcss_pkg::CSR_SLIDE_STYLE, pcss_pkg::STYLE_LEFT, 1'b0);
      write_register(pcss_pkg::CSR_AUTO_BACKWARD, 0, 1'b1);
      send_word(pcss_pkg::ACT_NEXT, '0);
      send_word(pcss_pkg::ACT_PREV, '0);
      repeat (6) send_word(pcss_pkg::ACT_TICK, '0);
      drain_views();
   endtask

   task automatic check_slide_targets();
      send_word(pcss_pkg::ACT_SLIDE_TO, 4'd15);
      send_word(pcss_pkg::ACT_JUMP, 4'd15);
      send_word(pcss_pkg::ACT_SLIDE_TO, 4'd0);
      send_word(pcss_pkg::ACT_JUMP, 4'd15);
      send_word(pcss_pkg::ACT_TICK, '0);
      send_word(pcss_pkg::ACT_TICK, '0);
      drain_views();
   endtask

   task automatic check_slide_lengths();
      // shrink the slide under a running one so the offsets saturate
      write_register(pcss_pkg::CSR_TICKS_PER_SLIDE, 1, 1'b1);
      send_word(ACT_SPARE_FIRST, '0);
      drain_views();
      write_register(pcss_pkg::CSR_TICKS_PER_SLIDE, 0, 1'b1);
      send_word(pcss_pkg::ACT_NEXT, '0);
      send_word(pcss_pkg::ACT_TICK, '0);
      drain_views();
      write_register(pcss_pkg::CSR_PAGE_COUNT, 3, 1'b0);
      write_register(pcss_pkg::CSR_SLIDE_STYLE, pcss_pkg::STYLE_DOWN, 1'b0);
      write_register(pcss_pkg::CSR_AUTO_BACKWARD, 1, 1'b1);
      send_word(pcss_pkg::ACT_SLIDE_TO, 4'd15);
      send_word(pcss_pkg::ACT_JUMP, 4'd3);
      send_word(pcss_pkg::ACT_JUMP, 4'd2);
      send_word(pcss_pkg::ACT_PREV, '0);
      send_word(pcss_pkg::ACT_TICK, '0);
      drain_views();
   endtask

   task automatic check_random_traffic();
      pcss_pkg::csr_index_type idx_q[$];
      logic [31:0]   val_q[$];
      logic [31:0]   pc, tpp, tps;
      int r, n;
      logic [2:0] act;
      logic [pcss_pkg::PAGE_W-1:0] tgt;
      for (int phase = 0; phase < PHASES; phase++) begin
         idx_q.delete();
         val_q.delete();
         case ($urandom_range(0, 9))
            0:       pc = 0;
            1:       pc = 1;
            2:       pc = pcss_pkg::MAX_PAGES;
            3:       pc = $urandom_range(pcss_pkg::MAX_PAGES + 1, 31);
            default: pc = $urandom_range(2, pcss_pkg::MAX_PAGES - 1);
         endcase
         tpp = $urandom_range(0, 6);
         r = $urandom_range(0, 9);
         tps = (r == 0) ? 0 : (r == 1) ? $urandom_range(40, 300) : $urandom_range(1, 12);
         if (phase == 1) begin
            idx_q = '{pcss_pkg::CSR_PAGE_COUNT, pcss_pkg::CSR_TICKS_PER_PAGE,
                      pcss_pkg::CSR_TICKS_PER_SLIDE, pcss_pkg::CSR_AUTO_ADVANCE,
                      pcss_pkg::CSR_SLIDE_STYLE, pcss_pkg::CSR_AUTO_BACKWARD};
            val_q = '{32'd31, 32'hFFFF, 32'hFFFF, 32'd1, pcss_pkg::STYLE_DOWN, 32'd1};
         end else if (phase == 2) begin
            idx_q = '{pcss_pkg::CSR_PAGE_COUNT, pcss_pkg::CSR_TICKS_PER_PAGE,
                      pcss_pkg::CSR_TICKS_PER_SLIDE, pcss_pkg::CSR_AUTO_ADVANCE,
                      pcss_pkg::CSR_SLIDE_STYLE, pcss_pkg::CSR_AUTO_BACKWARD};
            val_q = '{32'd1, 32'd0, 32'd0, 32'd0, pcss_pkg::STYLE_LEFT, 32'd0};
         end else begin
            if (phase == 0 || $urandom_range(0, 99) < 35) begin
               idx_q.push_back(pcss_pkg::CSR_PAGE_COUNT); val_q.push_back(pc);
            end
            if (phase == 0 || $urandom_range(0, 1)) begin
               idx_q.push_back(pcss_pkg::CSR_TICKS_PER_PAGE); val_q.push_back(tpp);
            end
            if (phase == 0 || $urandom_range(0, 1)) begin
               idx_q.push_back(pcss_pkg::CSR_TICKS_PER_SLIDE); val_q.push_back(tps);
            end
            if (phase == 0 || $urandom_range(0, 1)) begin
               idx_q.push_back(pcss_pkg::CSR_AUTO_ADVANCE);
               val_q.push_back($urandom_range(0, 1));
            end
            if (phase == 0 || $urandom_range(0, 1)) begin
               idx_q.push_back(pcss_pkg::CSR_SLIDE_STYLE);
               val_q.push_back($urandom_range(0, 3));
            end
            if (phase == 0 || $urandom_range(0, 1)) begin
               idx_q.push_back(pcss_pkg::CSR_AUTO_BACKWARD);
               val_q.push_back($urandom_range(0, 1));
            end
         end
         foreach (idx_q[i]) write_register(idx_q[i], val_q[i], i == idx_q.size() - 1);
         send_steady = ($urandom_range(0, 3) == 0);
         rsp_steady  = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < PHASE_WORDS; k++) begin
            r = $urandom_range(0, 99);
            if (r < 55)      act = pcss_pkg::ACT_TICK;
            else if (r < 65) act = pcss_pkg::ACT_NEXT;
            else if (r < 75) act = pcss_pkg::ACT_PREV;
            else if (r < 83) act = pcss_pkg::ACT_JUMP;
            else if (r < 95) act = pcss_pkg::ACT_SLIDE_TO;
            else             act = 3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
            n = pages_in_use();
            if (n > 0 && $urandom_range(0, 4) != 0)
               tgt = pcss_pkg::PAGE_W'($urandom_range(0, n - 1));
            else
               tgt = pcss_pkg::PAGE_W'($urandom_range(0, 15));
            send_word(act, tgt);
         end
         drain_views();
      end
      send_steady = 1'b0;
      rsp_steady  = 1'b0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall_left = 0;
      end else if (rsp_stall_left > 0) begin
         rsp_stall_left = rsp_stall_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_stall_left = pick_gap(rsp_steady);
         rsp_ready <= (rsp_stall_left == 0);
         if (rsp_stall_left > 0) rsp_stall_left = rsp_stall_left - 1;
      end
   end

   always @(posedge clock) begin : check_views
      carousel_view_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got.current_page  = rsp_current_page;
         got.incoming_page = rsp_incoming_page;
         got.sliding       = rsp_sliding;
         got.out_x         = rsp_out_x;
         got.out_y         = rsp_out_y;
         got.in_x          = rsp_in_x;
         got.in_y          = rsp_in_y;
         got.early_phase   = rsp_early_phase;
         got.late_phase    = rsp_late_phase;
         if (expected_views.size() == 0) begin
            if (failures < REPORT_LIMIT)
               $display("unexpected result word: %s", format_view(got));
            failures++;
         end else begin
            want = expected_views.pop_front();
            if (got !== want) begin
               if (failures < REPORT_LIMIT) begin
                  $display("view mismatch at %0t", $realtime);
                  $display("  expected %s", format_view(want));
                  $display("  actual   %s", format_view(got));
               end
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("page_carousel_slide_sequencer: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      check_frozen_carousel();
      check_manual_slides();
      check_slide_targets();
      check_slide_lengths();
      check_random_traffic();
      drain_views();
      repeat (SETTLE) @(posedge clock);
      if (failures == 0) begin
         $display("page_carousel_slide_sequencer: match");
      end else begin
         $display("page_carousel_slide_sequencer: mismatch");
      end
      $finish;
   end

endmodule
